[src/csh_pkg.sv]
// Shared types and constants of the cluster shower-shape block.
// Used by every module in src but csh_checker; depends on nothing else.
package csh_pkg;

  localparam int unsigned MaxHitsDefault    = 256;
  localparam int unsigned EnergyBitsDefault = 16;

  localparam int unsigned EW     = 16;  // hit energy
  localparam int unsigned PosW   = 6;   // row / column
  localparam int unsigned IdW    = 12;  // tower id
  localparam int unsigned CeW    = 24;  // cluster energy and weight sum
  localparam int unsigned MomW   = 30;  // first moments
  localparam int unsigned SqW    = 36;  // second moments
  localparam int unsigned ProdW  = 60;  // products of moments
  localparam int unsigned DenW   = 48;  // divisor width
  localparam int unsigned CapW   = 26;  // quotient width after capping
  localparam int unsigned DvdW   = 76;  // numerator shifted by up to 16

  localparam logic [CapW-1:0] CapFrac   = CapW'(65535);
  localparam logic [CapW-1:0] CapAsym   = CapW'(65536);
  localparam logic [CapW-1:0] CapSpread = CapW'(67108863);
  localparam logic [CapW-1:0] CapCovPos = CapW'(262143);
  localparam logic [CapW-1:0] CapCovNeg = CapW'(262144);

  // One finished cluster as handed from the front to the back.
  typedef struct packed {
    logic [CeW-1:0]  ce;
    logic [CeW-1:0]  w;
    logic [EW-1:0]   e1;
    logic [EW-1:0]   e2;
    logic            has2;
    logic [IdW-1:0]  tower;
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic [MomW-1:0] sc;
    logic [MomW-1:0] sr;
    logic [SqW-1:0]  scc;
    logic [SqW-1:0]  srr;
    logic [SqW-1:0]  scr;
  } csh_job_t;

  typedef struct packed {
    logic             start;
    logic [ProdW-1:0] num;
    logic [DenW-1:0]  den;
    logic [4:0]       sh;
    logic [CapW-1:0]  cap;
  } csh_div_req_t;

  typedef struct packed {
    logic            done;
    logic [CapW-1:0] quo;
  } csh_div_rsp_t;

endpackage

[src/csh_front.sv]
// Front end: registers each hit, tracks seed and second energy and
// accumulates the weighted moments. Depends on csh_pkg.
module csh_front #(
  parameter int unsigned MAX_HITS    = 256,
  parameter int unsigned ENERGY_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [csh_pkg::EW-1:0]   hit_energy_i,
  input  logic [csh_pkg::PosW-1:0] hit_row_i,
  input  logic [csh_pkg::PosW-1:0] hit_col_i,
  input  logic [csh_pkg::IdW-1:0]  hit_id_i,
  input  logic [csh_pkg::CeW-1:0]  cluster_energy_i,
  input  logic                     last_hit_i,
  output logic                     push_o,
  output csh_pkg::csh_job_t        push_data_o,
  input  logic                     full_i
);
  import csh_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_HITS + 1);
  localparam logic [EW-1:0] EMask = (ENERGY_BITS >= EW) ? {EW{1'b1}} :
                                    EW'((1 << ENERGY_BITS) - 1);

  logic             s1_valid_q;
  logic [EW-1:0]    s1_e_q;
  logic [PosW-1:0]  s1_row_q, s1_col_q;
  logic [IdW-1:0]   s1_id_q;
  logic [CeW-1:0]   s1_ce_q;
  logic             s1_last_q;
  logic [2*PosW-1:0] s1_csq_q, s1_rsq_q, s1_cr_q;

  logic [CntW-1:0]  hits_q, hits_n;
  logic [EW-1:0]    best_q, best_n, sec_q, sec_n;
  logic             sec_v_q, sec_v_n;
  logic [IdW-1:0]   tower_q, tower_n;
  logic [PosW-1:0]  brow_q, brow_n, bcol_q, bcol_n;
  logic [CeW-1:0]   w_q, w_n;
  logic [MomW-1:0]  sc_q, sc_n, sr_q, sr_n;
  logic [SqW-1:0]   scc_q, scc_n, srr_q, srr_n, scr_q, scr_n;

  logic                  adv, take, first;
  logic [EW+PosW-1:0]    ec, er;
  logic [EW+2*PosW-1:0]  ecc, err, ecr;

  assign adv        = s1_valid_q && (!s1_last_q || !full_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign take       = hits_q < CntW'(MAX_HITS);
  assign first      = (hits_q == '0);

  assign ec  = s1_e_q * s1_col_q;
  assign er  = s1_e_q * s1_row_q;
  assign ecc = s1_e_q * s1_csq_q;
  assign err = s1_e_q * s1_rsq_q;
  assign ecr = s1_e_q * s1_cr_q;

  always_comb begin
    hits_n  = hits_q;
    best_n  = best_q;
    sec_n   = sec_q;
    sec_v_n = sec_v_q;
    tower_n = tower_q;
    brow_n  = brow_q;
    bcol_n  = bcol_q;
    w_n     = w_q;
    sc_n    = sc_q;
    sr_n    = sr_q;
    scc_n   = scc_q;
    srr_n   = srr_q;
    scr_n   = scr_q;
    if (take) begin
      if (first || s1_e_q > best_q) begin
        if (!first) begin
          sec_n   = best_q;
          sec_v_n = 1'b1;
        end
        best_n  = s1_e_q;
        tower_n = s1_id_q;
        brow_n  = s1_row_q;
        bcol_n  = s1_col_q;
      end else if (!sec_v_q || s1_e_q > sec_q) begin
        sec_n   = s1_e_q;
        sec_v_n = 1'b1;
      end
      w_n    = w_q + CeW'(s1_e_q);
      sc_n   = sc_q + MomW'(ec);
      sr_n   = sr_q + MomW'(er);
      scc_n  = scc_q + SqW'(ecc);
      srr_n  = srr_q + SqW'(err);
      scr_n  = scr_q + SqW'(ecr);
      hits_n = hits_q + CntW'(1);
    end
  end

  assign push_o            = adv && s1_last_q;
  assign push_data_o.ce    = s1_ce_q;
  assign push_data_o.w     = w_n;
  assign push_data_o.e1    = best_n;
  assign push_data_o.e2    = sec_n;
  assign push_data_o.has2  = sec_v_n && (sec_n != '0);
  assign push_data_o.tower = tower_n;
  assign push_data_o.row   = brow_n;
  assign push_data_o.col   = bcol_n;
  assign push_data_o.sc    = sc_n;
  assign push_data_o.sr    = sr_n;
  assign push_data_o.scc   = scc_n;
  assign push_data_o.srr   = srr_n;
  assign push_data_o.scr   = scr_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_e_q    <= hit_energy_i & EMask;
      s1_row_q  <= hit_row_i;
      s1_col_q  <= hit_col_i;
      s1_id_q   <= hit_id_i;
      s1_ce_q   <= cluster_energy_i;
      s1_last_q <= last_hit_i;
      s1_csq_q  <= hit_col_i * hit_col_i;
      s1_rsq_q  <= hit_row_i * hit_row_i;
      s1_cr_q   <= hit_col_i * hit_row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q  <= '0;
      best_q  <= '0;
      sec_q   <= '0;
      sec_v_q <= 1'b0;
      tower_q <= '0;
      brow_q  <= '0;
      bcol_q  <= '0;
      w_q     <= '0;
      sc_q    <= '0;
      sr_q    <= '0;
      scc_q   <= '0;
      srr_q   <= '0;
      scr_q   <= '0;
    end else if (adv) begin
      if (s1_last_q) begin
        hits_q  <= '0;
        best_q  <= '0;
        sec_q   <= '0;
        sec_v_q <= 1'b0;
        tower_q <= '0;
        brow_q  <= '0;
        bcol_q  <= '0;
        w_q     <= '0;
        sc_q    <= '0;
        sr_q    <= '0;
        scc_q   <= '0;
        srr_q   <= '0;
        scr_q   <= '0;
      end else begin
        hits_q  <= hits_n;
        best_q  <= best_n;
        sec_q   <= sec_n;
        sec_v_q <= sec_v_n;
        tower_q <= tower_n;
        brow_q  <= brow_n;
        bcol_q  <= bcol_n;
        w_q     <= w_n;
        sc_q    <= sc_n;
        sr_q    <= sr_n;
        scc_q   <= scc_n;
        srr_q   <= srr_n;
        scr_q   <= scr_n;
      end
    end
  end

endmodule

[src/csh_fifo.sv]
// Two-entry queue of finished clusters between front and back.
// Depends on csh_pkg.
module csh_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  csh_pkg::csh_job_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output csh_pkg::csh_job_t data_o
);
  import csh_pkg::*;

  csh_job_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

[src/csh_div.sv]
// Restoring divider, one quotient bit per cycle, result capped.
// Depends on csh_pkg.
module csh_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  csh_pkg::csh_div_req_t req_i,
  output csh_pkg::csh_div_rsp_t rsp_o
);
  import csh_pkg::*;

  localparam int unsigned CntW = $clog2(DvdW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DvdW-1:0] dvd_q, quo_q;
  logic [DenW-1:0] rem_q, den_q;
  logic [CapW-1:0] cap_q;
  logic [DenW:0]   rs;
  logic            ge;

  assign rs = {rem_q, dvd_q[DvdW-1]};
  assign ge = rs >= {1'b0, den_q};

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = (quo_q > DvdW'(cap_q)) ? cap_q : quo_q[CapW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DvdW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= DvdW'(req_i.num) << req_i.sh;
      rem_q <= '0;
      quo_q <= '0;
      den_q <= req_i.den;
      cap_q <= req_i.cap;
    end else if (busy_q) begin
      rem_q <= ge ? DenW'(rs - {1'b0, den_q}) : rs[DenW-1:0];
      quo_q <= {quo_q[DvdW-2:0], ge};
      dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
    end
  end

endmodule

[src/csh_back.sv]
// Back end: sequencer that turns one finished cluster into its result with
// a serial multiplier, the shared divider and a serial square root.
// Depends on csh_pkg and csh_div.
module csh_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [csh_pkg::CeW-1:0]  min_energy_i,
  input  csh_pkg::csh_job_t        job_i,
  input  logic                     empty_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     cluster_kept_o,
  output logic [csh_pkg::IdW-1:0]  seed_tower_o,
  output logic [csh_pkg::PosW-1:0] seed_row_out_o,
  output logic [csh_pkg::PosW-1:0] seed_col_out_o,
  output logic [csh_pkg::EW-1:0]   seed_energy_o,
  output logic [15:0]              seed_fraction_o,
  output logic [15:0]              second_fraction_o,
  output logic [16:0]              top_two_asymmetry_o,
  output logic [12:0]              sigma_col_o,
  output logic [12:0]              sigma_row_o,
  output logic signed [18:0]       col_row_covariance_o
);
  import csh_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLoad = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StSqrt = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  localparam logic [3:0] StpFs  = 4'd0;
  localparam logic [3:0] StpSs  = 4'd1;
  localparam logic [3:0] StpAs  = 4'd2;
  localparam logic [3:0] StpWw  = 4'd3;
  localparam logic [3:0] StpCa  = 4'd4;
  localparam logic [3:0] StpCb  = 4'd5;
  localparam logic [3:0] StpCd  = 4'd6;
  localparam logic [3:0] StpRa  = 4'd7;
  localparam logic [3:0] StpRb  = 4'd8;
  localparam logic [3:0] StpRd  = 4'd9;
  localparam logic [3:0] StpXa  = 4'd10;
  localparam logic [3:0] StpXb  = 4'd11;
  localparam logic [3:0] StpXd  = 4'd12;
  localparam logic [3:0] StpEnd = 4'd13;

  logic [2:0] st_q, st_d;
  logic [3:0] step_q, step_d;

  csh_job_t         job_q;
  logic             kept_q;
  logic [15:0]      frac1_q, frac2_q;
  logic [16:0]      asym_q;
  logic [12:0]      sigc_q, sigr_q;
  logic [18:0]      cov_q;
  logic [ProdW-1:0] ww_q, a_q, b_q, ma_q, macc_q;
  logic [MomW-1:0]  mb_q;
  logic [CapW-1:0]  sx_q, sr_q, sb_q;
  logic             out_valid_q;

  csh_div_req_t     div_req;
  csh_div_rsp_t     div_rsp;
  logic [ProdW-1:0] diff;
  logic             a_ge_b, kept_new, load_out, mul_start;
  logic [ProdW-1:0] mul_a;
  logic [MomW-1:0]  mul_b;
  logic [CapW:0]    sq_t;

  csh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign a_ge_b   = a_q >= b_q;
  assign diff     = a_ge_b ? (a_q - b_q) : (b_q - a_q);
  assign kept_new = (job_i.ce >= min_energy_i) && (job_i.w != '0);
  assign pop_o    = (st_q == StIdle) && !empty_i;
  assign load_out = (st_q == StOut) && (!out_valid_q || out_ready_i);
  assign sq_t     = {1'b0, sr_q} + {1'b0, sb_q};

  // Sequencer next state and step, with the divider and multiplier launches per step.
  always_comb begin
    div_req   = '0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    step_d    = step_q;
    st_d      = st_q;
    unique case (st_q)
      StIdle: begin
        if (!empty_i) begin
          step_d = StpFs;
          st_d   = kept_new ? StLoad : StOut;
        end
      end
      StLoad: begin
        unique case (step_q)
          StpFs: begin
            if (job_q.ce != '0) begin
              div_req = '{1'b1, ProdW'(job_q.e1), DenW'(job_q.ce), 5'd16, CapFrac};
              st_d    = StDiv;
            end else begin
              step_d = step_q + 4'd1;
            end
          end
          StpSs: begin
            if (job_q.has2 && job_q.ce != '0) begin
              div_req = '{1'b1, ProdW'(job_q.e2), DenW'(job_q.ce), 5'd16, CapFrac};
              st_d    = StDiv;
            end else begin
              step_d = step_q + 4'd1;
            end
          end
          StpAs: begin
            if (job_q.has2 && job_q.e1 != '0) begin
              div_req = '{1'b1, ProdW'(job_q.e1 - job_q.e2),
                          DenW'({1'b0, job_q.e1} + {1'b0, job_q.e2}), 5'd16, CapAsym};
              st_d    = StDiv;
            end else begin
              step_d = step_q + 4'd1;
            end
          end
          StpWw: begin
            mul_start = 1'b1;
            mul_a     = ProdW'(job_q.w);
            mul_b     = MomW'(job_q.w);
            st_d      = StMul;
          end
          StpCa: begin
            mul_start = 1'b1;
            mul_a     = ProdW'(job_q.scc);
            mul_b     = MomW'(job_q.w);
            st_d      = StMul;
          end
          StpCb: begin
            mul_start = 1'b1;
            mul_a     = ProdW'(job_q.sc);
            mul_b     = job_q.sc;
            st_d      = StMul;
          end
          StpRa: begin
            mul_start = 1'b1;
            mul_a     = ProdW'(job_q.srr);
            mul_b     = MomW'(job_q.w);
            st_d      = StMul;
          end
          StpRb: begin
            mul_start = 1'b1;
            mul_a     = ProdW'(job_q.sr);
            mul_b     = job_q.sr;
            st_d      = StMul;
          end
          StpXa: begin
            mul_start = 1'b1;
            mul_a     = ProdW'(job_q.scr);
            mul_b     = MomW'(job_q.w);
            st_d      = StMul;
          end
          StpXb: begin
            mul_start = 1'b1;
            mul_a     = ProdW'(job_q.sr);
            mul_b     = job_q.sc;
            st_d      = StMul;
          end
          StpCd, StpRd: begin
            div_req = '{1'b1, diff, ww_q[DenW-1:0], 5'd16, CapSpread};
            st_d    = StDiv;
          end
          StpXd: begin
            div_req = '{1'b1, diff, ww_q[DenW-1:0], 5'd8,
                        a_ge_b ? CapCovPos : CapCovNeg};
            st_d    = StDiv;
          end
          default: st_d = StOut;
        endcase
      end
      StMul: begin
        if (mb_q == '0) begin
          step_d = step_q + 4'd1;
          st_d   = StLoad;
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          if (step_q == StpCd || step_q == StpRd) begin
            st_d = StSqrt;
          end else begin
            step_d = step_q + 4'd1;
            st_d   = StLoad;
          end
        end
      end
      StSqrt: begin
        if (sb_q == '0) begin
          step_d = step_q + 4'd1;
          st_d   = StLoad;
        end
      end
      StOut: begin
        if (load_out) begin
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      step_q      <= StpFs;
      out_valid_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q   <= job_i;
      kept_q  <= kept_new;
      frac1_q <= '0;
      frac2_q <= '0;
      asym_q  <= 17'd65536;
      sigc_q  <= '0;
      sigr_q  <= '0;
      cov_q   <= '0;
    end
    if (mul_start) begin
      ma_q   <= mul_a;
      mb_q   <= mul_b;
      macc_q <= '0;
    end else if (st_q == StMul) begin
      if (mb_q == '0) begin
        unique case (step_q)
          StpWw:               ww_q <= macc_q;
          StpCa, StpRa, StpXa: a_q  <= macc_q;
          default:             b_q  <= macc_q;
        endcase
      end else begin
        if (mb_q[0]) begin
          macc_q <= macc_q + ma_q;
        end
        ma_q <= {ma_q[ProdW-2:0], 1'b0};
        mb_q <= mb_q >> 1;
      end
    end
    if (st_q == StDiv && div_rsp.done) begin
      unique case (step_q)
        StpFs: frac1_q <= div_rsp.quo[15:0];
        StpSs: frac2_q <= div_rsp.quo[15:0];
        StpAs: asym_q  <= div_rsp.quo[16:0];
        StpXd: cov_q   <= a_ge_b ? div_rsp.quo[18:0] : (~div_rsp.quo[18:0] + 19'd1);
        default: begin
          sx_q <= div_rsp.quo;
          sr_q <= '0;
          sb_q <= CapW'(1) << (CapW - 2);
        end
      endcase
    end
    if (st_q == StSqrt) begin
      if (sb_q == '0) begin
        if (step_q == StpCd) begin
          sigc_q <= sr_q[12:0];
        end else begin
          sigr_q <= sr_q[12:0];
        end
      end else begin
        if ({1'b0, sx_q} >= sq_t) begin
          sx_q <= CapW'({1'b0, sx_q} - sq_t);
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q <= sb_q >> 2;
      end
    end
    if (load_out) begin
      cluster_kept_o       <= kept_q;
      seed_tower_o         <= kept_q ? job_q.tower : '0;
      seed_row_out_o       <= kept_q ? job_q.row : '0;
      seed_col_out_o       <= kept_q ? job_q.col : '0;
      seed_energy_o        <= kept_q ? job_q.e1 : '0;
      seed_fraction_o      <= kept_q ? frac1_q : '0;
      second_fraction_o    <= kept_q ? frac2_q : '0;
      top_two_asymmetry_o  <= kept_q ? asym_q : '0;
      sigma_col_o          <= kept_q ? sigc_q : '0;
      sigma_row_o          <= kept_q ? sigr_q : '0;
      col_row_covariance_o <= kept_q ? $signed(cov_q) : '0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[src/cluster_shower_shape.sv]
// Top level of the cluster shower-shape block: threshold register, front
// end, cluster queue and back end. Depends on csh_pkg, csh_front,
// csh_fifo and csh_back.
//
// Usage. Hits of one cluster enter on the input channel (in_valid_i /
// in_ready_o), one item per cycle while in_ready_o is high, the final hit
// flagged by last_hit_i. The front end registers each hit and folds it
// into the seed tracking and the weighted moment sums, so hits stream in
// back to back. On the last hit the cluster summary goes into a two-entry
// queue. The back end takes one cluster at a time and works it out with a
// serial multiplier (one multiplier bit per cycle), a restoring divider
// (76 quotient bits) and a serial square root (13 steps). That back end
// sequence sets the sustained rate per cluster. The result item sits in
// an output register on out_valid_o until out_ready_i takes it; a stalled
// receiver holds the back end, then the queue fills and finally in_ready_o
// drops on a last hit. The threshold is written on the cfg channel, always
// ready; the user must write it only while the block is idle, and the
// block itself does not enforce this. Reset clears the threshold, all sums
// and the queue; no item is pending.
module cluster_shower_shape #(
  parameter int unsigned MAX_HITS    = csh_pkg::MaxHitsDefault,
  parameter int unsigned ENERGY_BITS = csh_pkg::EnergyBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [csh_pkg::CeW-1:0]  cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [csh_pkg::EW-1:0]   hit_energy_i,
  input  logic [csh_pkg::PosW-1:0] hit_row_i,
  input  logic [csh_pkg::PosW-1:0] hit_col_i,
  input  logic [csh_pkg::IdW-1:0]  hit_id_i,
  input  logic [csh_pkg::CeW-1:0]  cluster_energy_i,
  input  logic                     last_hit_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     cluster_kept_o,
  output logic [csh_pkg::IdW-1:0]  seed_tower_o,
  output logic [csh_pkg::PosW-1:0] seed_row_out_o,
  output logic [csh_pkg::PosW-1:0] seed_col_out_o,
  output logic [csh_pkg::EW-1:0]   seed_energy_o,
  output logic [15:0]              seed_fraction_o,
  output logic [15:0]              second_fraction_o,
  output logic [16:0]              top_two_asymmetry_o,
  output logic [12:0]              sigma_col_o,
  output logic [12:0]              sigma_row_o,
  output logic signed [18:0]       col_row_covariance_o
);
  import csh_pkg::*;

  logic [CeW-1:0] min_energy_q;
  logic           push, full, pop, empty;
  csh_job_t       push_data, pop_data;

  // The threshold register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_energy_q <= '0;
    end else if (cfg_valid_i) begin
      min_energy_q <= cfg_data_i;
    end
  end

  csh_front #(
    .MAX_HITS    (MAX_HITS),
    .ENERGY_BITS (ENERGY_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .hit_energy_i     (hit_energy_i),
    .hit_row_i        (hit_row_i),
    .hit_col_i        (hit_col_i),
    .hit_id_i         (hit_id_i),
    .cluster_energy_i (cluster_energy_i),
    .last_hit_i       (last_hit_i),
    .push_o           (push),
    .push_data_o      (push_data),
    .full_i           (full)
  );

  // Finished clusters wait here so the front end keeps taking hits while
  // the back end is busy with an earlier cluster.
  csh_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_data)
  );

  csh_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .min_energy_i         (min_energy_q),
    .job_i                (pop_data),
    .empty_i              (empty),
    .pop_o                (pop),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .cluster_kept_o       (cluster_kept_o),
    .seed_tower_o         (seed_tower_o),
    .seed_row_out_o       (seed_row_out_o),
    .seed_col_out_o       (seed_col_out_o),
    .seed_energy_o        (seed_energy_o),
    .seed_fraction_o      (seed_fraction_o),
    .second_fraction_o    (second_fraction_o),
    .top_two_asymmetry_o  (top_two_asymmetry_o),
    .sigma_col_o          (sigma_col_o),
    .sigma_row_o          (sigma_row_o),
    .col_row_covariance_o (col_row_covariance_o)
  );

endmodule

[src/csh_checker.sv]
// Port-level checks on the result channel of cluster_shower_shape, and
// the bind that attaches them. Depends only on the top level's ports.
module csh_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              cluster_kept_o,
  input logic [11:0]       seed_tower_o,
  input logic [15:0]       seed_energy_o,
  input logic [15:0]       seed_fraction_o,
  input logic [16:0]       top_two_asymmetry_o,
  input logic [12:0]       sigma_col_o,
  input logic signed [18:0] col_row_covariance_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(seed_energy_o) && $stable(sigma_col_o)
      && $stable(cluster_kept_o) && $stable(col_row_covariance_o))
    else $error("stalled result item changed");

  a_dropped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cluster_kept_o |-> seed_tower_o == 12'd0 && seed_energy_o == 16'd0
      && seed_fraction_o == 16'd0 && top_two_asymmetry_o == 17'd0
      && sigma_col_o == 13'd0 && col_row_covariance_o == 19'sd0)
    else $error("cluster not kept but result fields are not zero");

  a_asym_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cluster_kept_o |-> top_two_asymmetry_o <= 17'd65536)
    else $error("asymmetry above one");

endmodule

bind cluster_shower_shape csh_checker u_csh_checker (.*);

[bench/cluster_shower_shape_tb.sv]
// Self-checking testbench of cluster_shower_shape: directed table of hits, then random clusters.
// Results are predicted in-bench from the hits and the threshold, or typed by hand in table rows.
// Depends on csh_pkg and the cluster_shower_shape RTL only.
`timescale 1ns / 1ps

module cluster_shower_shape_tb;
  import csh_pkg::*;

  localparam int unsigned LimitCycles = 10000000;
  localparam int unsigned MaxHits     = 256;
  localparam int unsigned DrainCycles = 1200;  // longer than one kept cluster in the back end
  localparam int unsigned LongHold    = 5000;

  // Expected shape summary of one cluster, at the widths of the output ports.
  typedef struct packed {
    logic               kept;
    logic [IdW-1:0]     tower;
    logic [PosW-1:0]    row;
    logic [PosW-1:0]    col;
    logic [EW-1:0]      e1;
    logic [15:0]        seed_frac;
    logic [15:0]        sec_frac;
    logic [16:0]        asym;
    logic [12:0]        sig_col;
    logic [12:0]        sig_row;
    logic signed [18:0] cov;
  } shape_t;

  typedef struct {
    logic [EW-1:0]   e;
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic [IdW-1:0]  id;
    logic [CeW-1:0]  ce;
    logic            last;
    logic            typed;   // expected shape given by hand in this row
    shape_t          shape;
  } hit_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CeW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [EW-1:0] hit_e = '0;
  logic [PosW-1:0] hit_r = '0;
  logic [PosW-1:0] hit_c = '0;
  logic [IdW-1:0] hit_id = '0;
  logic [CeW-1:0] clu_e = '0;
  logic last_hit = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  shape_t got;

  cluster_shower_shape u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .hit_energy_i(hit_e), .hit_row_i(hit_r), .hit_col_i(hit_c), .hit_id_i(hit_id),
    .cluster_energy_i(clu_e), .last_hit_i(last_hit),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .cluster_kept_o(got.kept), .seed_tower_o(got.tower), .seed_row_out_o(got.row),
    .seed_col_out_o(got.col), .seed_energy_o(got.e1), .seed_fraction_o(got.seed_frac),
    .second_fraction_o(got.sec_frac), .top_two_asymmetry_o(got.asym),
    .sigma_col_o(got.sig_col), .sigma_row_o(got.sig_row),
    .col_row_covariance_o(got.cov)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the threshold and of the per-cluster accumulators.
  logic [CeW-1:0]  min_energy = '0;
  int unsigned     hits_in_cluster = 0;
  logic [EW-1:0]   top_e = '0, next_e = '0;
  logic            next_ok = 1'b0;
  logic [IdW-1:0]  top_id = '0;
  logic [PosW-1:0] top_r = '0, top_c = '0;
  logic [CeW-1:0]  wsum = '0;
  logic [MomW-1:0] sum_c = '0, sum_r = '0;
  logic [SqW-1:0]  sum_cc = '0, sum_rr = '0, sum_cr = '0;

  shape_t shape_q[$];
  int unsigned errors = 0, cycles = 0, hits_sent = 0, clusters = 0, kept_seen = 0;
  int unsigned burst_left = 0;
  bit long_hold_req = 1'b0;

  // floor(num * 2^sh / den) limited to cap; den is never zero here.
  function automatic logic [63:0] frac_div(logic [63:0] num, logic [63:0] den, int sh,
                                           logic [63:0] cap);
    logic [63:0] whole, rest, v;
    whole = num / den;
    rest  = num % den;
    if (whole > (cap >> sh)) return cap;
    v = (whole << sh) + ((rest << sh) / den);
    return (v > cap) ? cap : v;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Energy-weighted spread along one axis, Q8 cells.
  function automatic logic [12:0] axis_spread(logic [63:0] w, logic [63:0] m, logic [63:0] sq);
    logic [63:0] a, b;
    a = w * sq;
    b = m * m;
    return 13'(int_sqrt(frac_div((a >= b) ? a - b : b - a, w * w, 16, 64'd67108863)));
  endfunction

  // Folds one hit into the shadow sums; on a last hit returns the shape summary.
  function automatic bit fold_hit(hit_row_t h, output shape_t s);
    logic [63:0] e, a, b, cv;
    logic        has2;
    e = 64'(h.e);
    s = '0;
    if (hits_in_cluster < MaxHits) begin
      if (hits_in_cluster == 0 || h.e > top_e) begin
        if (hits_in_cluster != 0) begin
          next_e  = top_e;
          next_ok = 1'b1;
        end
        top_e  = h.e;
        top_id = h.id;
        top_r  = h.row;
        top_c  = h.col;
      end else if (!next_ok || h.e > next_e) begin
        next_e  = h.e;
        next_ok = 1'b1;
      end
      wsum   = CeW'(64'(wsum) + e);
      sum_c  = MomW'(64'(sum_c) + e * h.col);
      sum_r  = MomW'(64'(sum_r) + e * h.row);
      sum_cc = SqW'(64'(sum_cc) + e * h.col * h.col);
      sum_rr = SqW'(64'(sum_rr) + e * h.row * h.row);
      sum_cr = SqW'(64'(sum_cr) + e * h.col * h.row);
      hits_in_cluster++;
    end
    if (!h.last) return 1'b0;
    if (h.ce >= min_energy && wsum != 0) begin
      has2        = next_ok && next_e != 0;
      s.kept      = 1'b1;
      s.tower     = top_id;
      s.row       = top_r;
      s.col       = top_c;
      s.e1        = top_e;
      s.seed_frac = (h.ce != 0) ? 16'(frac_div(top_e, h.ce, 16, 65535)) : '0;
      s.sec_frac  = (has2 && h.ce != 0) ? 16'(frac_div(next_e, h.ce, 16, 65535)) : '0;
      s.asym      = (top_e != 0 && has2) ?
                    17'(frac_div(top_e - next_e, 64'(top_e) + next_e, 16, 65536)) : 17'd65536;
      s.sig_col   = axis_spread(wsum, sum_c, sum_cc);
      s.sig_row   = axis_spread(wsum, sum_r, sum_rr);
      a = 64'(wsum) * sum_cr;
      b = 64'(sum_c) * sum_r;
      if (a >= b) cv = frac_div(a - b, 64'(wsum) * wsum, 8, 262143);
      else cv = 64'd0 - frac_div(b - a, 64'(wsum) * wsum, 8, 262144);
      s.cov = 19'(cv);
    end
    hits_in_cluster = 0;
    top_e = '0; next_e = '0; next_ok = 1'b0; top_id = '0; top_r = '0; top_c = '0;
    wsum = '0; sum_c = '0; sum_r = '0; sum_cc = '0; sum_rr = '0; sum_cr = '0;
    return 1'b1;
  endfunction

  // Offers one hit, waits for its acceptance, then maybe leaves a gap in the burst.
  task automatic send_hit(hit_row_t h);
    shape_t s;
    in_valid <= 1'b1;
    hit_e    <= h.e;
    hit_r    <= h.row;
    hit_c    <= h.col;
    hit_id   <= h.id;
    clu_e    <= h.ce;
    last_hit <= h.last;
    do @(posedge clk); while (!in_ready);
    hits_sent++;
    if (fold_hit(h, s)) begin
      clusters++;
      shape_q.insert(shape_q.size(), h.typed ? h.shape : s);
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (shape_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_threshold(logic [CeW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    min_energy  = v;
  endtask

  function automatic logic [EW-1:0] pick_energy(logic [EW-1:0] prev);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 16'hFFFF;
      2: return prev;                       // ties with an earlier hit
      3, 4: return EW'($urandom_range(0, 255));
      default: return EW'($urandom);
    endcase
  endfunction

  // One random cluster of n hits; the cluster energy is near the hit sum or arbitrary.
  task automatic send_cluster(int unsigned n);
    hit_row_t    h;
    logic [63:0] tot;
    logic [EW-1:0] prev;
    tot  = 0;
    prev = EW'($urandom);
    for (int unsigned i = 0; i < n; i++) begin
      h.e     = pick_energy(prev);
      prev    = h.e;
      tot    += h.e;
      h.row   = ($urandom_range(0, 15) == 0) ? PosW'($urandom_range(0, 1) * 63) : PosW'($urandom);
      h.col   = ($urandom_range(0, 15) == 0) ? PosW'($urandom_range(0, 1) * 63) : PosW'($urandom);
      h.id    = IdW'($urandom);
      h.last  = (i == n - 1);
      h.typed = 1'b0;
      h.shape = '0;
      case ($urandom_range(0, 7))
        0: h.ce = '0;
        1: h.ce = 24'hFFFFFF;
        2, 3: h.ce = CeW'($urandom);
        default: h.ce = (tot > 24'hFFFFFF) ? 24'hFFFFFF : CeW'(tot + $urandom_range(0, 64));
      endcase
      send_hit(h);
    end
  endtask

  // Directed table. Hand-typed shapes are the ones readable at a glance.
  hit_row_t table_rows[$];

  task automatic add_row(logic [EW-1:0] e, logic [PosW-1:0] r, logic [PosW-1:0] c,
                         logic [IdW-1:0] id, logic [CeW-1:0] ce, logic last,
                         logic typed, shape_t s);
    hit_row_t h;
    h = '{e, r, c, id, ce, last, typed, s};
    table_rows.insert(table_rows.size(), h);
  endtask

  // The receiver alternates between always ready, coin-flip and mostly stalled
  // stretches; on request it holds off for a long run so the block backs up.
  initial begin
    int unsigned mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    shape_t want;
    if (rst_n && out_valid && out_ready) begin
      if (shape_q.size() == 0) begin
        $error("result with no cluster pending");
        errors++;
      end else begin
        want = shape_q.pop_front();
        if (got.kept) kept_seen++;
        if (got.kept !== want.kept) begin
          $error("cluster_kept: expected %0d, got %0d", want.kept, got.kept); errors++;
        end
        if (got.tower !== want.tower) begin
          $error("seed_tower: expected %0d, got %0d", want.tower, got.tower); errors++;
        end
        if (got.row !== want.row) begin
          $error("seed_row_out: expected %0d, got %0d", want.row, got.row); errors++;
        end
        if (got.col !== want.col) begin
          $error("seed_col_out: expected %0d, got %0d", want.col, got.col); errors++;
        end
        if (got.e1 !== want.e1) begin
          $error("seed_energy: expected %0d, got %0d", want.e1, got.e1); errors++;
        end
        if (got.seed_frac !== want.seed_frac) begin
          $error("seed_fraction: expected %0d, got %0d", want.seed_frac, got.seed_frac);
          errors++;
        end
        if (got.sec_frac !== want.sec_frac) begin
          $error("second_fraction: expected %0d, got %0d", want.sec_frac, got.sec_frac);
          errors++;
        end
        if (got.asym !== want.asym) begin
          $error("top_two_asymmetry: expected %0d, got %0d", want.asym, got.asym); errors++;
        end
        if (got.sig_col !== want.sig_col) begin
          $error("sigma_col: expected %0d, got %0d", want.sig_col, got.sig_col); errors++;
        end
        if (got.sig_row !== want.sig_row) begin
          $error("sigma_row: expected %0d, got %0d", want.sig_row, got.sig_row); errors++;
        end
        if (got.cov !== want.cov) begin
          $error("col_row_covariance: expected %0d, got %0d", want.cov, got.cov); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("cluster_shower_shape: mismatch");
      $finish;
    end
  end

  initial begin
    shape_t z, one_hit;
    z = '0;
    one_hit = '0;
    one_hit.kept = 1'b1;
    one_hit.row  = 6'd1;
    one_hit.col  = 6'd1;
    one_hit.e1   = 16'd1;
    one_hit.asym = 17'd65536;

    // Zero weight is never kept; a lone unit hit has no spread and no second.
    add_row(16'd0, 6'd1, 6'd1, 12'd7, 24'd0, 1'b1, 1'b1, z);
    add_row(16'd1, 6'd1, 6'd1, 12'd0, 24'd0, 1'b1, 1'b1, one_hit);
    add_row(16'hFFFF, 6'd63, 6'd63, 12'hFFF, 24'hFFFFFF, 1'b1, 1'b0, z);
    // Ties keep the first seed, a strictly higher hit demotes it to second,
    // and zero row or column are used as given.
    add_row(16'd500, 6'd5, 6'd5, 12'd1, 24'd0, 1'b0, 1'b0, z);
    add_row(16'd500, 6'd6, 6'd7, 12'd2, 24'd0, 1'b0, 1'b0, z);
    add_row(16'd600, 6'd0, 6'd0, 12'd3, 24'd0, 1'b0, 1'b0, z);
    add_row(16'd550, 6'd63, 6'd0, 12'd4, 24'd0, 1'b0, 1'b0, z);
    add_row(16'd0, 6'd9, 6'd9, 12'd5, 24'd2150, 1'b1, 1'b0, z);
    // A zero second hit leaves the asymmetry at full scale.
    add_row(16'd100, 6'd3, 6'd4, 12'd8, 24'd100, 1'b0, 1'b0, z);
    add_row(16'd0, 6'd3, 6'd5, 12'd9, 24'd100, 1'b1, 1'b0, z);
    // All-zero hits give no weight.
    add_row(16'd0, 6'd2, 6'd2, 12'd10, 24'd5, 1'b0, 1'b0, z);
    add_row(16'd0, 6'd2, 6'd3, 12'd11, 24'd5, 1'b1, 1'b1, z);
    // Seed energy above the cluster energy saturates the fraction.
    add_row(16'd1000, 6'd10, 6'd10, 12'd12, 24'd500, 1'b0, 1'b0, z);
    add_row(16'd900, 6'd11, 6'd12, 12'd13, 24'd500, 1'b1, 1'b0, z);
    // Anti-correlated corners give a negative covariance.
    add_row(16'd40000, 6'd1, 6'd63, 12'd14, 24'd80000, 1'b0, 1'b0, z);
    add_row(16'd40000, 6'd63, 6'd1, 12'd15, 24'd80000, 1'b1, 1'b0, z);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_threshold(24'd0);
    foreach (table_rows[i]) send_hit(table_rows[i]);
    wait_drained();

    // Random phases, each under its own threshold, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_threshold(24'hFFFFFF);
        1: write_threshold(24'd0);
        2: write_threshold(24'd1);
        3: write_threshold(CeW'($urandom_range(0, 300000)));
        4: write_threshold(CeW'($urandom));
        default: write_threshold(24'd0);
      endcase
      if (ph == 1) begin
        // Back up the block: single-hit clusters against a stalled receiver.
        long_hold_req = 1'b1;
        for (int k = 0; k < 12; k++) send_cluster(1);
      end
      if (ph == 2) send_cluster($urandom_range(MaxHits + 1, MaxHits + 40));
      while (hits_sent < 300 * (ph + 1) + 16) begin
        send_cluster(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 14));
        if ($urandom_range(0, 40) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d hits in %0d clusters; %0d results kept, over 7 threshold settings.",
             hits_sent, clusters, kept_seen);
    if (errors == 0 && shape_q.size() == 0) begin
      $display("cluster_shower_shape: match");
    end else begin
      $display("cluster_shower_shape: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
src/csh_pkg.sv
src/csh_front.sv
src/csh_fifo.sv
src/csh_div.sv
src/csh_back.sv
src/cluster_shower_shape.sv
src/csh_checker.sv
bench/cluster_shower_shape_tb.sv
